/* rtl/rtcp_compound_packet_walker_top_defines.svh */
// Assertion macros shared by the RTL of the compound packet walker.
`ifndef RTCP_COMPOUND_PACKET_WALKER_TOP_DEFINES_SVH
`define RTCP_COMPOUND_PACKET_WALKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define RCPW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define RCPW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RCPW_ASSERT_NOW(lbl, ante, cons, msg)
`define RCPW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/rcpw_pkg.sv */
// Types and constants of the compound packet walker.
`default_nettype none

package rcpw_pkg;

	localparam int LEN_W   = 16;     // buffer length / byte offset width
	localparam int PLEN_W  = 19;     // packet length in bytes
	localparam int CNT_W   = 14;     // accepted packet count
	localparam int HDR_W   = 24;     // first three header bytes

	localparam logic [CNT_W-1:0] COUNT_MAX   = 14'd16383;
	localparam logic [1:0]       RTCP_VER    = 2'd2;
	localparam logic [LEN_W:0]   HDR_BYTES   = 17'd4;

	localparam logic KIND_DESC    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic              result_kind;
		logic [7:0]        packet_type;
		logic [LEN_W-1:0]  packet_offset;
		logic [PLEN_W-1:0] packet_length;
		logic [CNT_W-1:0]  accepted_packets;
		logic              buffer_error;
		logic              last_result;
	} result_t;

endpackage

`default_nettype wire

/* rtl/rtcp_compound_packet_walker_top.sv */
// Top level of the compound RTCP packet walker.
// Use:
//   The input channel takes one byte of a compound RTCP buffer per beat
//   (data_byte), with first_byte marking the buffer's first byte and
//   buffer_length sampled on that beat. The walker gathers each 4-byte
//   common header, checks version 2 and that the packet fits the buffer,
//   and sends one descriptor beat (type, offset, length, running count) per
//   good packet. After the buffer's last byte a summary beat (last_result
//   set) carries the packet count and a short-buffer error flag. A bad
//   header stops the walk; the rest of the buffer is swallowed silently.
// Timing:
//   One byte per cycle sustained while the result queue has room. A byte
//   is registered, then processed by the walker state logic when the
//   input stage advances; its results go into the result queue that drives
//   the output. One byte can give two beats (a descriptor and the summary).
// Stall:
//   Results queue in a 4-entry buffer; the input stage holds while that
//   buffer has fewer than two free entries, so nothing is lost when the
//   receiver stalls.
// Reset: arst_n clears walker state, the input stage and the result queue.
`default_nettype none
`include "rtcp_compound_packet_walker_top_defines.svh"

module rtcp_compound_packet_walker_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [7:0]                 data_byte,
	input  wire logic                       first_byte,
	input  wire logic [rcpw_pkg::LEN_W-1:0] buffer_length,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            result_kind,
	output logic [7:0]                      packet_type,
	output logic [rcpw_pkg::LEN_W-1:0]      packet_offset,
	output logic [rcpw_pkg::PLEN_W-1:0]     packet_length,
	output logic [rcpw_pkg::CNT_W-1:0]      accepted_packets,
	output logic                            buffer_error,
	output logic                            last_result
);
	import rcpw_pkg::*;

	// ---------------- input stage ----------------
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             first_s1;
	logic [LEN_W-1:0] blen_s1;
	logic             adv;       // stage 1 beat processed this cycle

	// ---------------- walker state ----------------
	logic [LEN_W-1:0]  total_q, pos_q, start_q;
	logic [1:0]        phase_q;
	logic [HDR_W-1:0]  hdr_q;
	logic [PLEN_W-1:0] skip_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              stop_q;

	logic [LEN_W-1:0]  total_n, pos_n, start_n;
	logic [1:0]        phase_n;
	logic [HDR_W-1:0]  hdr_n;
	logic [PLEN_W-1:0] skip_n;
	logic [CNT_W-1:0]  cnt_n;
	logic              stop_n;

	logic [LEN_W-1:0]  pos_e;
	logic [15:0]       words;
	logic [PLEN_W-1:0] plen;
	logic              desc_hit, sum_hit;
	result_t           desc_r, sum_r, res0, res1;
	logic [1:0]        push_n;

	// ---------------- result queue ----------------
	result_t    fifo_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] fcnt_q;
	logic       pop;

	// Stage 1 advances when the queue can take two more beats.
	assign adv      = valid_s1 && (fcnt_q <= 3'd2);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
			blen_s1  <= buffer_length;
		end
	end

	// Walker step. A first byte restarts from cleared state with the new length.
	always_comb begin
		total_n = first_s1 ? blen_s1 : total_q;
		pos_e   = first_s1 ? '0 : pos_q;
		start_n = first_s1 ? '0 : start_q;
		phase_n = first_s1 ? '0 : phase_q;
		hdr_n   = first_s1 ? '0 : hdr_q;
		skip_n  = first_s1 ? '0 : skip_q;
		cnt_n   = first_s1 ? '0 : cnt_q;
		stop_n  = first_s1 ? 1'b0 : stop_q;
		pos_n   = pos_e;
		desc_hit = 1'b0;
		sum_hit  = 1'b0;
		words   = {hdr_n[7:0], byte_s1};
		plen    = {1'b0, words, 2'b00} + PLEN_W'(4);

		if (pos_e < total_n) begin
			if (!stop_n) begin
				if (skip_n != '0) begin
					skip_n = skip_n - PLEN_W'(1);
				end else if (phase_n == 2'd0) begin
					if ({1'b0, pos_e} + HDR_BYTES > {1'b0, total_n}) begin
						stop_n = 1'b1;
					end else begin
						start_n = pos_e;
						hdr_n   = {16'd0, byte_s1};
						phase_n = 2'd1;
					end
				end else if (phase_n != 2'd3) begin
					hdr_n   = {hdr_n[15:0], byte_s1};
					phase_n = phase_n + 2'd1;
				end else begin
					phase_n = 2'd0;
					if (hdr_n[23:22] != RTCP_VER ||
					    {4'd0, start_n} + {1'b0, plen} > {4'd0, total_n}) begin
						stop_n = 1'b1;
					end else begin
						if (cnt_n != COUNT_MAX) cnt_n = cnt_n + CNT_W'(1);
						desc_hit = 1'b1;
						skip_n   = plen - PLEN_W'(4);
					end
				end
			end
			pos_n = pos_e + LEN_W'(1);
			sum_hit = (pos_n == total_n);
		end
	end

	always_comb begin
		desc_r = '{result_kind: KIND_DESC, packet_type: hdr_q[15:8] & {8{!first_s1}},
			packet_offset: start_n, packet_length: plen, accepted_packets: cnt_n,
			buffer_error: 1'b0, last_result: 1'b0};
		sum_r  = '{result_kind: KIND_SUMMARY, packet_type: 8'd0, packet_offset: '0,
			packet_length: '0, accepted_packets: cnt_n,
			buffer_error: ({1'b0, total_n} < HDR_BYTES), last_result: 1'b1};
		res0   = desc_hit ? desc_r : sum_r;
		res1   = sum_r;
		push_n = {1'b0, desc_hit} + {1'b0, sum_hit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			pos_q   <= '0;
			start_q <= '0;
			phase_q <= '0;
			hdr_q   <= '0;
			skip_q  <= '0;
			cnt_q   <= '0;
			stop_q  <= 1'b0;
		end else if (adv) begin
			total_q <= total_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			phase_q <= phase_n;
			hdr_q   <= hdr_n;
			skip_q  <= skip_n;
			cnt_q   <= cnt_n;
			stop_q  <= stop_n;
		end
	end

	// Result queue: up to two writes, one read per cycle.
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (adv && push_n != 2'd0) fifo_q[wr_q] <= res0;
		if (adv && push_n == 2'd2) fifo_q[wr_q + 2'd1] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fcnt_q <= '0;
		end else begin
			if (adv) wr_q <= wr_q + push_n;
			if (pop) rd_q <= rd_q + 2'd1;
			fcnt_q <= fcnt_q + (adv ? {1'b0, push_n} : 3'd0) - {2'd0, pop};
		end
	end

	assign out_valid        = (fcnt_q != 3'd0);
	assign result_kind      = fifo_q[rd_q].result_kind;
	assign packet_type      = fifo_q[rd_q].packet_type;
	assign packet_offset    = fifo_q[rd_q].packet_offset;
	assign packet_length    = fifo_q[rd_q].packet_length;
	assign accepted_packets = fifo_q[rd_q].accepted_packets;
	assign buffer_error     = fifo_q[rd_q].buffer_error;
	assign last_result      = fifo_q[rd_q].last_result;

	// ---------------- checks ----------------
	`RCPW_ASSERT_NOW(a_fifo_bound, 1'b1, fcnt_q <= 3'd4, "result queue overflow")
	`RCPW_ASSERT_NOW(a_no_adv_full, fcnt_q > 3'd2, !adv, "stage advanced with queue near full")
	`RCPW_ASSERT_NOW(a_desc_fields, out_valid && result_kind == KIND_DESC,
		!last_result && !buffer_error, "descriptor carries summary flags")
	`RCPW_ASSERT_NEXT(a_stop_holds, stop_q && !(adv && first_s1), stop_q,
		"walk restarted without a first byte")
	`RCPW_ASSERT_NEXT(a_fill_track, adv && !pop,
		fcnt_q == $past(fcnt_q) + {1'b0, $past(push_n)}, "queue fill miscounted")

endmodule

`default_nettype wire
